/* hw/rtl/look_at_view_matrix_assert.svh */
// Assertion macros used by the look_at_view_matrix module.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LAV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look_at_view_matrix: assertion failed");

// Next-cycle implication, disabled during reset.
`define LAV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look_at_view_matrix: assertion failed");

`endif

/* hw/rtl/lav_pkg.sv */
`default_nettype none
package lav_pkg;
    localparam int MAG_W   = 48;
    localparam int NRM_W   = 30;
    localparam int RAD_W   = 2 * NRM_W + 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int Q14_W   = 16;
    localparam int Q14_FRAC = 14;
    localparam int SIDE_W  = 192;

    typedef logic [MAG_W-1:0]          t_mag;
    typedef logic [SIDE_W-1:0]         t_side;
    typedef logic [2:0][Q14_W-1:0]     t_q14x3;

    typedef struct packed {
        t_mag [2:0] mag;
        logic [2:0] neg;
    } t_nrm_in;

    typedef struct packed {
        logic [2:0][NRM_W-1:0] m;
        logic [2:0]            neg;
        logic                  zero;
        t_side                 side;
    } t_nrm_pay;
endpackage
`default_nettype wire

/* hw/rtl/lav_in_if.sv */
`default_nettype none
interface lav_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] hint_up_x;
    logic signed [31:0] hint_up_y;
    logic signed [31:0] hint_up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               hint_up_x, hint_up_y, hint_up_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               hint_up_x, hint_up_y, hint_up_z,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/lav_out_if.sv */
`default_nettype none
interface lav_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic signed [15:0] side_z;
    logic signed [15:0] true_up_x;
    logic signed [15:0] true_up_y;
    logic signed [15:0] true_up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;

    modport source (
        output valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/lav_isqrt.sv */
`default_nettype none
module lav_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_v,
    input  logic [lav_pkg::RAD_W-1:0]     i_rad,
    input  lav_pkg::t_nrm_pay             i_pay,
    output logic                          o_v,
    output logic [lav_pkg::ROOT_W-1:0]    o_root,
    output lav_pkg::t_nrm_pay             o_pay
);
    localparam int NST   = lav_pkg::ROOT_W;
    localparam int REM_W = lav_pkg::ROOT_W + 2;

    logic                         r_v    [0:NST];
    logic [lav_pkg::RAD_W-1:0]    r_rad  [0:NST];
    logic [lav_pkg::ROOT_W-1:0]   r_root [0:NST];
    logic [REM_W-1:0]             r_rem  [0:NST];
    lav_pkg::t_nrm_pay            r_pay  [0:NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_pay[0]  <= i_pay;
        end
    end

    // One root bit per stage: bring down two radicand bits, try 4r+1.
    for (genvar j = 0; j < NST; j++) begin : g_st
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             ge;

        assign acc   = {r_rem[j], r_rad[j][lav_pkg::RAD_W-1-2*j -: 2]};
        assign trial = {2'b00, r_root[j], 2'b01};
        assign diff  = acc - trial;
        assign ge    = acc >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j+1]  <= r_rad[j];
                r_root[j+1] <= {r_root[j][lav_pkg::ROOT_W-2:0], ge};
                r_rem[j+1]  <= ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
                r_pay[j+1]  <= r_pay[j];
            end
        end
    end

    assign o_v    = r_v[NST];
    assign o_root = r_root[NST];
    assign o_pay  = r_pay[NST];
endmodule
`default_nettype wire

/* hw/rtl/lav_norm.sv */
`default_nettype none
module lav_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_v,
    input  lav_pkg::t_nrm_in   i_vec,
    input  lav_pkg::t_side     i_side,
    output logic               o_v,
    output lav_pkg::t_q14x3    o_unit,
    output lav_pkg::t_side     o_side
);
    localparam int WW    = lav_pkg::MAG_W + lav_pkg::NRM_W;
    localparam int NSH   = $clog2(WW);
    localparam int NQ    = lav_pkg::Q14_FRAC + 2;
    localparam int NUM_W = lav_pkg::NRM_W + lav_pkg::Q14_FRAC + 1;
    localparam int DV_W  = lav_pkg::ROOT_W + NQ;
    localparam int SQ_W  = 2 * lav_pkg::NRM_W;

    // leading-one alignment, coarse to fine
    logic                 r_sv    [0:NSH];
    logic [2:0][WW-1:0]   r_w     [0:NSH];
    logic [2:0]           r_sneg  [0:NSH];
    lav_pkg::t_side       r_sside [0:NSH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_w[0][i] <= {i_vec.mag[i], {lav_pkg::NRM_W{1'b0}}};
            end
            r_sneg[0]  <= i_vec.neg;
            r_sside[0] <= i_side;
        end
    end

    for (genvar j = 1; j <= NSH; j++) begin : g_sh
        localparam int K = 2 ** (NSH - j);
        logic [WW-1:0] top_or;
        logic          hit;

        assign top_or = r_w[j-1][0] | r_w[j-1][1] | r_w[j-1][2];
        assign hit    = ~|top_or[WW-1 -: K];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (i_en) begin
                r_sv[j] <= r_sv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_w[j][i] <= hit ? (r_w[j-1][i] << K) : r_w[j-1][i];
                end
                r_sneg[j]  <= r_sneg[j-1];
                r_sside[j] <= r_sside[j-1];
            end
        end
    end

    // squares
    logic                               r_qv;
    logic [2:0][lav_pkg::NRM_W-1:0]     r_qm;
    logic [2:0][SQ_W-1:0]               r_sq;
    logic [2:0]                         r_qneg;
    logic                               r_qzero;
    lav_pkg::t_side                     r_qside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else if (i_en) begin
            r_qv <= r_sv[NSH];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [lav_pkg::NRM_W-1:0] m;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                m = r_w[NSH][i][WW-1 -: lav_pkg::NRM_W];
                r_qm[i] <= m;
                r_sq[i] <= SQ_W'(m) * SQ_W'(m);
            end
            r_qneg  <= r_sneg[NSH];
            r_qzero <= ~(r_w[NSH][0][WW-1] | r_w[NSH][1][WW-1] | r_w[NSH][2][WW-1]);
            r_qside <= r_sside[NSH];
        end
    end

    logic [lav_pkg::RAD_W-1:0]  rad;
    lav_pkg::t_nrm_pay          sq_pay;
    logic                       rt_v;
    logic [lav_pkg::ROOT_W-1:0] rt_len;
    lav_pkg::t_nrm_pay          rt_pay;

    assign rad = lav_pkg::RAD_W'(r_sq[0]) + lav_pkg::RAD_W'(r_sq[1])
               + lav_pkg::RAD_W'(r_sq[2]);
    assign sq_pay = '{m: r_qm, neg: r_qneg, zero: r_qzero, side: r_qside};

    lav_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_v     (r_qv),
        .i_rad   (rad),
        .i_pay   (sq_pay),
        .o_v     (rt_v),
        .o_root  (rt_len),
        .o_pay   (rt_pay)
    );

    // restoring division, one quotient bit per stage, three lanes
    logic                        r_dv   [0:NQ];
    logic [2:0][NUM_W-1:0]       r_num  [0:NQ];
    logic [2:0][NQ-1:0]          r_q    [0:NQ];
    logic [lav_pkg::ROOT_W-1:0]  r_len  [0:NQ];
    logic [2:0]                  r_dneg [0:NQ];
    logic                        r_dzero[0:NQ];
    lav_pkg::t_side              r_dside[0:NQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[0][i] <= NUM_W'({rt_pay.m[i], {lav_pkg::Q14_FRAC{1'b0}}})
                             + NUM_W'(rt_len >> 1);
                r_q[0][i]   <= '0;
            end
            r_len[0]   <= rt_len;
            r_dneg[0]  <= rt_pay.neg;
            r_dzero[0] <= rt_pay.zero;
            r_dside[0] <= rt_pay.side;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_div
        localparam int B = NQ - 1 - k;
        logic [DV_W-1:0] dv;
        assign dv = DV_W'(r_len[k]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [DV_W-1:0] numx;
            logic [DV_W-1:0] diff;
            logic            ge;
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    numx = DV_W'(r_num[k][i]);
                    diff = numx - dv;
                    ge   = numx >= dv;
                    r_num[k+1][i] <= ge ? diff[NUM_W-1:0] : r_num[k][i];
                    r_q[k+1][i]   <= {r_q[k][i][NQ-2:0], ge};
                end
                r_len[k+1]   <= r_len[k];
                r_dneg[k+1]  <= r_dneg[k];
                r_dzero[k+1] <= r_dzero[k];
                r_dside[k+1] <= r_dside[k];
            end
        end
    end

    // sign and zero vector
    logic             r_ov;
    lav_pkg::t_q14x3  r_ounit;
    lav_pkg::t_side   r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [lav_pkg::Q14_W-1:0] q;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                q = r_q[NQ][i];
                if (r_dzero[NQ]) begin
                    r_ounit[i] <= '0;
                end else if (r_dneg[NQ][i]) begin
                    r_ounit[i] <= ~q + lav_pkg::Q14_W'(1);
                end else begin
                    r_ounit[i] <= q;
                end
            end
            r_oside <= r_dside[NQ];
        end
    end

    assign o_v    = r_ov;
    assign o_unit = r_ounit;
    assign o_side = r_oside;
endmodule
`default_nettype wire

/* hw/rtl/look_at_view_matrix.sv */
// Throughput: one item per cycle while the skid is empty; every stage advances together,
//   one root bit and one quotient bit per stage in the two normalizers set the depth.
// A two-entry output (register plus skid) keeps input ready up while one result waits.
// Reset (synchronous, active low) clears all valid bits; no clearing pass is needed.
`default_nettype none
`include "look_at_view_matrix_assert.svh"
module look_at_view_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lav_in_if.sink      i_in,
    lav_out_if.source   o_out
);
    typedef struct packed {
        lav_pkg::t_q14x3 side;
        lav_pkg::t_q14x3 up;
        lav_pkg::t_q14x3 back;
        logic [2:0][31:0] shift;
    } t_res;

    // Round a Q.30 value to Q16.16 (floor; the caller adds the half first) and saturate.
    function automatic logic [31:0] rnd_sat(input logic signed [50:0] x);
        logic signed [50:0] y;
        y = x >>> lav_pkg::Q14_FRAC;
        if (y > 51'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (y < -51'sd2147483648) begin
            return 32'h8000_0000;
        end
        return y[31:0];
    endfunction

    // Whole pipeline advances unless the skid is occupied.
    logic en;
    logic r_skid_v;
    assign en = !r_skid_v;
    assign i_in.ready = en;

    // Stage 0: capture the beat.
    logic               r_s0_v;
    logic signed [31:0] r_s0_e [3];
    logic signed [31:0] r_s0_t [3];
    logic signed [31:0] r_s0_h [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_e[0] <= i_in.eye_x;
            r_s0_e[1] <= i_in.eye_y;
            r_s0_e[2] <= i_in.eye_z;
            r_s0_t[0] <= i_in.target_x;
            r_s0_t[1] <= i_in.target_y;
            r_s0_t[2] <= i_in.target_z;
            r_s0_h[0] <= i_in.hint_up_x;
            r_s0_h[1] <= i_in.hint_up_y;
            r_s0_h[2] <= i_in.hint_up_z;
        end
    end

    // Stage 1: view direction, 33 bits so no difference wraps.
    logic               r_s1_v;
    logic signed [32:0] r_s1_d [3];
    logic signed [31:0] r_s1_e [3];
    logic signed [31:0] r_s1_h [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_d[i] <= $signed({r_s0_t[i][31], r_s0_t[i]})
                           - $signed({r_s0_e[i][31], r_s0_e[i]});
                r_s1_e[i] <= r_s0_e[i];
                r_s1_h[i] <= r_s0_h[i];
            end
        end
    end

    // Forward normalizer: magnitudes and signs in, eye and hint ride along.
    lav_pkg::t_nrm_in n1_in;
    lav_pkg::t_side   n1_side;
    logic             n1_v;
    lav_pkg::t_q14x3  n1_f;
    lav_pkg::t_side   n1_oside;

    always_comb begin
        logic [32:0] dabs;
        for (int i = 0; i < 3; i++) begin
            dabs = r_s1_d[i][32] ? (~r_s1_d[i] + 33'd1) : r_s1_d[i];
            n1_in.mag[i] = lav_pkg::t_mag'(dabs);
            n1_in.neg[i] = r_s1_d[i][32];
        end
    end
    assign n1_side = {r_s1_e[0], r_s1_e[1], r_s1_e[2], r_s1_h[0], r_s1_h[1], r_s1_h[2]};

    lav_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r_s1_v),
        .i_vec   (n1_in),
        .i_side  (n1_side),
        .o_v     (n1_v),
        .o_unit  (n1_f),
        .o_side  (n1_oside)
    );

    // Cross stage 1: the six partial products of forward x hint.
    logic               r_x1_v;
    logic signed [47:0] r_x1_p [6];
    logic signed [31:0] r_x1_e [3];
    lav_pkg::t_q14x3    r_x1_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
        end else if (en) begin
            r_x1_v <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [15:0] f [3];
        logic signed [31:0] h [3];
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                f[i] = $signed(n1_f[i]);
                h[i] = $signed(n1_oside[95-32*i -: 32]);
                r_x1_e[i] <= $signed(n1_oside[191-32*i -: 32]);
            end
            r_x1_p[0] <= f[1] * h[2];
            r_x1_p[1] <= f[2] * h[1];
            r_x1_p[2] <= f[2] * h[0];
            r_x1_p[3] <= f[0] * h[2];
            r_x1_p[4] <= f[0] * h[1];
            r_x1_p[5] <= f[1] * h[0];
            r_x1_f    <= n1_f;
        end
    end

    // Cross stage 2: differences; magnitude stays below 2^46.
    logic               r_x2_v;
    logic signed [47:0] r_x2_c [3];
    logic signed [31:0] r_x2_e [3];
    lav_pkg::t_q14x3    r_x2_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x2_v <= 1'b0;
        end else if (en) begin
            r_x2_v <= r_x1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_x2_c[i] <= r_x1_p[2*i] - r_x1_p[2*i+1];
                r_x2_e[i] <= r_x1_e[i];
            end
            r_x2_f <= r_x1_f;
        end
    end

    // Side normalizer: eye and forward ride along.
    lav_pkg::t_nrm_in n2_in;
    lav_pkg::t_side   n2_side;
    logic             n2_v;
    lav_pkg::t_q14x3  n2_s;
    lav_pkg::t_side   n2_oside;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_in.mag[i] = r_x2_c[i][47] ? lav_pkg::t_mag'(~r_x2_c[i] + 48'd1)
                                         : lav_pkg::t_mag'(r_x2_c[i]);
            n2_in.neg[i] = r_x2_c[i][47];
        end
    end
    assign n2_side = {r_x2_e[0], r_x2_e[1], r_x2_e[2], r_x2_f, 48'd0};

    lav_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r_x2_v),
        .i_vec   (n2_in),
        .i_side  (n2_side),
        .o_v     (n2_v),
        .o_unit  (n2_s),
        .o_side  (n2_oside)
    );

    // Finish stage 1: side x forward products, side.eye and forward.eye terms.
    logic               r_u1_v;
    logic signed [31:0] r_u1_p  [6];
    logic signed [47:0] r_u1_se [3];
    logic signed [47:0] r_u1_fe [3];
    logic signed [31:0] r_u1_e  [3];
    lav_pkg::t_q14x3    r_u1_s;
    lav_pkg::t_q14x3    r_u1_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1_v <= 1'b0;
        end else if (en) begin
            r_u1_v <= n2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [15:0] s [3];
        logic signed [15:0] f [3];
        logic signed [31:0] e [3];
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s[i] = $signed(n2_s[i]);
                // forward lane i sits above the zero pad, lane 0 lowest
                f[i] = $signed(n2_oside[48+16*i +: 16]);
                e[i] = $signed(n2_oside[191-32*i -: 32]);
            end
            r_u1_p[0] <= s[1] * f[2];
            r_u1_p[1] <= s[2] * f[1];
            r_u1_p[2] <= s[2] * f[0];
            r_u1_p[3] <= s[0] * f[2];
            r_u1_p[4] <= s[0] * f[1];
            r_u1_p[5] <= s[1] * f[0];
            for (int i = 0; i < 3; i++) begin
                r_u1_se[i] <= s[i] * e[i];
                r_u1_fe[i] <= f[i] * e[i];
                r_u1_e[i]  <= e[i];
                r_u1_f[i]  <= f[i];
            end
            r_u1_s <= n2_s;
        end
    end

    // Finish stage 2: round and clamp true up, sum the two dot products.
    logic               r_u2_v;
    lav_pkg::t_q14x3    r_u2_u;
    logic signed [49:0] r_u2_ds;
    logic signed [49:0] r_u2_df;
    logic signed [31:0] r_u2_e [3];
    lav_pkg::t_q14x3    r_u2_s;
    lav_pkg::t_q14x3    r_u2_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u2_v <= 1'b0;
        end else if (en) begin
            r_u2_v <= r_u1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [33:0] ur;
        logic signed [33:0] sh;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ur = $signed({{2{r_u1_p[2*i][31]}}, r_u1_p[2*i]})
                   - $signed({{2{r_u1_p[2*i+1][31]}}, r_u1_p[2*i+1]}) + 34'sd8192;
                sh = ur >>> lav_pkg::Q14_FRAC;
                if (sh > 34'sd16384) begin
                    r_u2_u[i] <= 16'sd16384;
                end else if (sh < -34'sd16384) begin
                    r_u2_u[i] <= -16'sd16384;
                end else begin
                    r_u2_u[i] <= sh[15:0];
                end
                r_u2_e[i] <= r_u1_e[i];
            end
            r_u2_ds <= $signed({{2{r_u1_se[0][47]}}, r_u1_se[0]})
                     + $signed({{2{r_u1_se[1][47]}}, r_u1_se[1]})
                     + $signed({{2{r_u1_se[2][47]}}, r_u1_se[2]});
            r_u2_df <= $signed({{2{r_u1_fe[0][47]}}, r_u1_fe[0]})
                     + $signed({{2{r_u1_fe[1][47]}}, r_u1_fe[1]})
                     + $signed({{2{r_u1_fe[2][47]}}, r_u1_fe[2]});
            r_u2_s <= r_u1_s;
            r_u2_f <= r_u1_f;
        end
    end

    // Finish stage 3: up.eye terms; translation x and z.
    logic               r_u3_v;
    logic signed [47:0] r_u3_ue [3];
    logic [31:0]        r_u3_tx;
    logic [31:0]        r_u3_tz;
    lav_pkg::t_q14x3    r_u3_u;
    lav_pkg::t_q14x3    r_u3_s;
    lav_pkg::t_q14x3    r_u3_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u3_v <= 1'b0;
        end else if (en) begin
            r_u3_v <= r_u2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u3_ue[i] <= $signed(r_u2_u[i]) * r_u2_e[i];
            end
            // negate and round in one subtract
            r_u3_tx <= rnd_sat(51'sd8192 - $signed({r_u2_ds[49], r_u2_ds}));
            r_u3_tz <= rnd_sat($signed({r_u2_df[49], r_u2_df}) + 51'sd8192);
            r_u3_u  <= r_u2_u;
            r_u3_s  <= r_u2_s;
            r_u3_f  <= r_u2_f;
        end
    end

    // Finish stage 4: sum up.eye.
    logic               r_u4_v;
    logic signed [49:0] r_u4_du;
    logic [31:0]        r_u4_tx;
    logic [31:0]        r_u4_tz;
    lav_pkg::t_q14x3    r_u4_u;
    lav_pkg::t_q14x3    r_u4_s;
    lav_pkg::t_q14x3    r_u4_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u4_v <= 1'b0;
        end else if (en) begin
            r_u4_v <= r_u3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u4_du <= $signed({{2{r_u3_ue[0][47]}}, r_u3_ue[0]})
                     + $signed({{2{r_u3_ue[1][47]}}, r_u3_ue[1]})
                     + $signed({{2{r_u3_ue[2][47]}}, r_u3_ue[2]});
            r_u4_tx <= r_u3_tx;
            r_u4_tz <= r_u3_tz;
            r_u4_u  <= r_u3_u;
            r_u4_s  <= r_u3_s;
            r_u4_f  <= r_u3_f;
        end
    end

    // Finish stage 5: translation y and back = -forward.
    logic r_u5_v;
    t_res r_u5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u5_v <= 1'b0;
        end else if (en) begin
            r_u5_v <= r_u4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u5.side     <= r_u4_s;
            r_u5.up       <= r_u4_u;
            for (int i = 0; i < 3; i++) begin
                r_u5.back[i] <= ~r_u4_f[i] + 16'd1;
            end
            r_u5.shift[0] <= r_u4_tx;
            r_u5.shift[1] <= rnd_sat(51'sd8192 - $signed({r_u4_du[49], r_u4_du}));
            r_u5.shift[2] <= r_u4_tz;
        end
    end

    // Output register and skid: take the last stage when it moves, park it
    // in the skid if the output beat is stalled, drain the skid first.
    logic r_out_v;
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_u5_v) begin
            if (r_out_v && !o_out.ready) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (r_u5_v) begin
            if (r_out_v && !o_out.ready) begin
                r_skid <= r_u5;
            end else begin
                r_out <= r_u5;
            end
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.side_x    = r_out.side[0];
    assign o_out.side_y    = r_out.side[1];
    assign o_out.side_z    = r_out.side[2];
    assign o_out.true_up_x = r_out.up[0];
    assign o_out.true_up_y = r_out.up[1];
    assign o_out.true_up_z = r_out.up[2];
    assign o_out.back_x    = r_out.back[0];
    assign o_out.back_y    = r_out.back[1];
    assign o_out.back_z    = r_out.back[2];
    assign o_out.shift_x   = r_out.shift[0];
    assign o_out.shift_y   = r_out.shift[1];
    assign o_out.shift_z   = r_out.shift[2];

    // A parked beat always has a beat in front of it.
    `LAV_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    // A finished beat meeting a stalled output must land in the skid.
    `LAV_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n,
        r_out_v && !o_out.ready && !r_skid_v && r_u5_v, r_skid_v)
    // A taken output beat drains the skid and keeps the output full.
    `LAV_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n,
        r_skid_v && o_out.ready, !r_skid_v && r_out_v)
endmodule
`default_nettype wire
